@@ hw/rtl/fwrm_pkg.sv @@
// ----------------------------------------------------------------------------
// fwrm_pkg
// Shared types and constants of the windowed frame rate meter: field widths,
// the Q8 milliseconds-per-second constant and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package fwrm_pkg;

  localparam int TS_W   = 32;  // timestamp and interval width
  localparam int FPS_W  = 24;  // rate output, Q16.8
  localparam int AVG_W  = 32;  // mean interval output
  localparam int FA_W   = 5;   // frames_averaged output
  localparam int STEP_W = 6;   // divider step counter

  // 1000 ms per second scaled by 2^8
  localparam int                 MS_Q8_W     = 18;
  localparam logic [MS_Q8_W-1:0] MS_PER_S_Q8 = 18'd256000;

  localparam logic [FPS_W-1:0] FPS_MAX = {FPS_W{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic capture;    // take the input beat, read the ring slot
    logic update;     // write ring, update sum, slot, count, last timestamp
    logic start_fps;  // start divider on 256000*count / sum
    logic start_avg;  // start divider on sum / count
    logic fps_latch;  // keep the rate quotient
    logic avg_latch;  // keep the mean quotient
    logic load_out;   // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sum_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage : fwrm_pkg

@@ hw/rtl/fwrm_div.sv @@
// ----------------------------------------------------------------------------
// fwrm_div
// Restoring divider, one quotient bit per cycle. The caller preloads the
// partial remainder and the dividend bits, and gives the number of steps.
// ----------------------------------------------------------------------------
module fwrm_div #(
  parameter int SUM_W = 36
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [SUM_W-1:0]            rem_init,
  input  logic [fwrm_pkg::TS_W-1:0]   quo_init,
  input  logic [SUM_W-1:0]            divisor,
  input  logic [fwrm_pkg::STEP_W-1:0] steps,
  output logic                        done,
  output logic [fwrm_pkg::TS_W-1:0]   quotient
);

  logic [SUM_W-1:0]            rem_r, rem_nxt;
  logic [fwrm_pkg::TS_W-1:0]   quo_r, quo_nxt;
  logic [SUM_W-1:0]            div_r;
  logic [fwrm_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  logic [SUM_W:0]   shifted;
  logic [SUM_W+1:0] diff;
  logic             ge;

  always_comb begin
    shifted = {rem_r, quo_r[fwrm_pkg::TS_W-1]};
    diff    = {1'b0, shifted} - {2'b00, div_r};
    ge      = ~diff[SUM_W+1];
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      quo_nxt  = quo_init;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      quo_nxt = {quo_r[fwrm_pkg::TS_W-2:0], ge};
      cnt_nxt = cnt_r - fwrm_pkg::STEP_W'(1);
      if (cnt_r == fwrm_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) div_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == fwrm_pkg::STEP_W'(1)) |=> (done_r && !busy_r))
    else $error("divider did not finish after its last step");
`endif

endmodule : fwrm_div

@@ hw/rtl/fwrm_dp.sv @@
// ----------------------------------------------------------------------------
// fwrm_dp
// Datapath: interval ring memory, running sum, slot and frame counters, the
// shared divider, and the output register.
// ----------------------------------------------------------------------------
module fwrm_dp #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fwrm_pkg::TS_W-1:0]  in_timestamp_ms,
  input  fwrm_pkg::cmd_t             cmd,
  output fwrm_pkg::sts_t             sts,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [fwrm_pkg::FPS_W-1:0] out_fps_q8,
  output logic [fwrm_pkg::AVG_W-1:0] out_avg_interval_ms,
  output logic [fwrm_pkg::FA_W-1:0]  out_frames_averaged,
  output logic                       out_zero_interval
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = fwrm_pkg::TS_W + $clog2(WINDOW_DEPTH);
  localparam int NUM_W  = fwrm_pkg::MS_Q8_W + CNT_W;
  localparam int TS_W   = fwrm_pkg::TS_W;

  logic [TS_W-1:0] ring_mem [WINDOW_DEPTH];

  logic [TS_W-1:0]   ts_r, interval_r, old_r;
  logic [TS_W-1:0]   last_ts_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              full;

  logic [fwrm_pkg::FPS_W-1:0] fps_res_r;
  logic [fwrm_pkg::AVG_W-1:0] avg_res_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [fwrm_pkg::FPS_W-1:0] out_fps_r;
  logic [fwrm_pkg::AVG_W-1:0] out_avg_r;
  logic [fwrm_pkg::FA_W-1:0]  out_fa_r;
  logic                       out_zero_r;

  logic                        div_start;
  logic [SUM_W-1:0]            div_rem_init;
  logic [TS_W-1:0]             div_quo_init;
  logic [SUM_W-1:0]            div_divisor;
  logic [fwrm_pkg::STEP_W-1:0] div_steps;
  logic                        div_done;
  logic [TS_W-1:0]             div_quotient;
  logic [NUM_W-1:0]            fps_num;
  logic [fwrm_pkg::FPS_W-1:0]  fps_sat;

  // ring: read the slot on capture, write the new interval on update
  always_ff @(posedge clk) begin
    if (cmd.capture) old_r <= ring_mem[slot_r];
    if (cmd.update) ring_mem[slot_r] <= interval_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ts_r       <= in_timestamp_ms;
      interval_r <= in_timestamp_ms - last_ts_r;
    end
  end

  always_comb begin
    full      = (count_r == CNT_W'(WINDOW_DEPTH));
    slot_nxt  = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
    count_nxt = full ? count_r : count_r + CNT_W'(1);
    // oldest interval leaves the sum once the window is full
    sum_nxt   = sum_r - (full ? SUM_W'(old_r) : '0) + SUM_W'(interval_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ts_r <= '0;
      slot_r    <= '0;
      count_r   <= '0;
      sum_r     <= '0;
    end else if (cmd.update) begin
      last_ts_r <= ts_r;
      slot_r    <= slot_nxt;
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
    end
  end

  // divider operands: rate numerator is left-aligned so NUM_W steps suffice
  always_comb begin
    fps_num   = NUM_W'(fwrm_pkg::MS_PER_S_Q8) * NUM_W'(count_r);
    div_start = cmd.start_fps | cmd.start_avg;
    if (cmd.start_avg) begin
      div_rem_init = SUM_W'(sum_r >> TS_W);
      div_quo_init = sum_r[TS_W-1:0];
      div_divisor  = SUM_W'(count_r);
      div_steps    = fwrm_pkg::STEP_W'(TS_W);
    end else begin
      div_rem_init = '0;
      div_quo_init = {fps_num, {(TS_W - NUM_W){1'b0}}};
      div_divisor  = sum_r;
      div_steps    = fwrm_pkg::STEP_W'(NUM_W);
    end
  end

  fwrm_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .quo_init (div_quo_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign fps_sat = (|div_quotient[TS_W-1:fwrm_pkg::FPS_W]) ? fwrm_pkg::FPS_MAX
                                                           : div_quotient[fwrm_pkg::FPS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.fps_latch) fps_res_r <= fps_sat;
    if (cmd.avg_latch) avg_res_r <= div_quotient;
  end

  // output register
  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_fa_r <= fwrm_pkg::FA_W'(count_r);
      if (sum_r == '0) begin
        out_fps_r  <= fwrm_pkg::FPS_MAX;
        out_avg_r  <= '0;
        out_zero_r <= 1'b1;
      end else begin
        out_fps_r  <= fps_res_r;
        out_avg_r  <= avg_res_r;
        out_zero_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.sum_zero = (sum_r == '0);
    sts.div_done = div_done;
    sts.out_free = ~out_valid_r | ~out_stall;
  end

  assign out_valid           = out_valid_r;
  assign out_fps_q8          = out_fps_r;
  assign out_avg_interval_ms = out_avg_r;
  assign out_frames_averaged = out_fa_r;
  assign out_zero_interval   = out_zero_r;

`ifndef SYNTHESIS
  a_empty_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (sum_r == '0))
    else $error("interval sum non-zero with no frames seen");
`endif

endmodule : fwrm_dp

@@ hw/rtl/fwrm_ctrl.sv @@
// ----------------------------------------------------------------------------
// fwrm_ctrl
// Controller: sequences one frame event through ring update, rate division,
// mean division and output load; a zero interval sum skips both divisions.
// ----------------------------------------------------------------------------
module fwrm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output fwrm_pkg::cmd_t cmd,
  input  fwrm_pkg::sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UPD     = 7'b0000010,
    S_FPS_GO  = 7'b0000100,
    S_FPS_RUN = 7'b0001000,
    S_AVG_GO  = 7'b0010000,
    S_AVG_RUN = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_FPS_GO;
      end
      S_FPS_GO: begin
        // zero sum needs no division
        if (sts.sum_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start_fps = 1'b1;
          state_nxt     = S_FPS_RUN;
        end
      end
      S_FPS_RUN: begin
        if (sts.div_done) begin
          cmd.fps_latch = 1'b1;
          state_nxt     = S_AVG_GO;
        end
      end
      S_AVG_GO: begin
        cmd.start_avg = 1'b1;
        state_nxt     = S_AVG_RUN;
      end
      S_AVG_RUN: begin
        if (sts.div_done) begin
          cmd.avg_latch = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output loaded while occupied and stalled");

  a_accept_goes_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_UPD))
    else $error("accepted beat not followed by ring update");
`endif

endmodule : fwrm_ctrl

@@ hw/rtl/windowed_frame_rate_meter.sv @@
// A beat goes through capture, ring update, rate and mean division and output load, which
// waits for a free output; a zero interval sum skips the divisions. in_stall is high until
// the load, so no new beat is taken before it. The shared one-bit-per-cycle divider runs
// the rate (NUM_W = 18+clog2(WINDOW_DEPTH+1) steps), then the mean (32 steps).
// Reset (rst_n low, synchronous): empty window, zero sum, last timestamp zero,
// output register empty. The interval ring holds no reset value.
// ----------------------------------------------------------------------------
// windowed_frame_rate_meter
// Moving-average frame rate meter: frames per second in Q16.8 and mean frame
// interval over the last WINDOW_DEPTH millisecond-stamped frame events.
// ----------------------------------------------------------------------------
module windowed_frame_rate_meter #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fwrm_pkg::TS_W-1:0]  in_timestamp_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fwrm_pkg::FPS_W-1:0] out_fps_q8,
  output logic [fwrm_pkg::AVG_W-1:0] out_avg_interval_ms,
  output logic [fwrm_pkg::FA_W-1:0]  out_frames_averaged,
  output logic                       out_zero_interval
);

  fwrm_pkg::cmd_t cmd;
  fwrm_pkg::sts_t sts;

  fwrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  fwrm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_timestamp_ms     (in_timestamp_ms),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_fps_q8          (out_fps_q8),
    .out_avg_interval_ms (out_avg_interval_ms),
    .out_frames_averaged (out_frames_averaged),
    .out_zero_interval   (out_zero_interval)
  );

endmodule : windowed_frame_rate_meter

@@ dv/windowed_frame_rate_meter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_frame_rate_meter_tb
// Sends millisecond-stamped frame beats and checks every result beat against
// a running model of the interval window: Q16.8 rate, mean interval, frame
// count and the zero-sum flag. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module windowed_frame_rate_meter_tb;

  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 4000;  // cycles with no beat on either side
  localparam int TAIL       = 70;    // wait after the last expected result is checked

  typedef struct packed {
    logic [fwrm_pkg::FPS_W-1:0] fps_q8;
    logic [fwrm_pkg::AVG_W-1:0] avg_interval_ms;
    logic [fwrm_pkg::FA_W-1:0]  frames_averaged;
    logic                       zero_interval;
  } meter_reading_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [fwrm_pkg::TS_W-1:0]  in_timestamp_ms = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [fwrm_pkg::FPS_W-1:0] out_fps_q8;
  logic [fwrm_pkg::AVG_W-1:0] out_avg_interval_ms;
  logic [fwrm_pkg::FA_W-1:0]  out_frames_averaged;
  logic                       out_zero_interval;

  windowed_frame_rate_meter #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_timestamp_ms     (in_timestamp_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_fps_q8          (out_fps_q8),
    .out_avg_interval_ms (out_avg_interval_ms),
    .out_frames_averaged (out_frames_averaged),
    .out_zero_interval   (out_zero_interval)
  );

  // window model
  logic [fwrm_pkg::TS_W-1:0] window_gap [DEPTH];
  int                        window_slot  = 0;
  int                        window_fill  = 0;
  logic [fwrm_pkg::TS_W-1:0] meter_last_ts = '0;
  logic [35:0]               window_sum   = '0;

  meter_reading_t expected_readings [$];
  int             send_idle_pct = 28;
  int             stall_pct     = 55;
  int             fault_count   = 0;
  int             idle_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("windowed_frame_rate_meter_tb: done, errors");
    $finish;
  end

  // one frame event through the window: evict, insert, then rate and mean
  task automatic predict_reading(input logic [fwrm_pkg::TS_W-1:0] ts);
    logic [fwrm_pkg::TS_W-1:0] gap;
    logic [63:0]               rate;
    meter_reading_t            want;
    gap = ts - meter_last_ts;
    if (window_fill >= DEPTH) window_sum = window_sum - window_gap[window_slot];
    window_gap[window_slot] = gap;
    window_sum  = window_sum + gap;
    window_slot = (window_slot == DEPTH - 1) ? 0 : window_slot + 1;
    meter_last_ts = ts;
    if (window_fill < DEPTH) window_fill++;
    want.frames_averaged = fwrm_pkg::FA_W'(window_fill);
    if (window_sum == 0) begin
      want.fps_q8          = fwrm_pkg::FPS_MAX;
      want.avg_interval_ms = '0;
      want.zero_interval   = 1'b1;
    end else begin
      rate = (64'(fwrm_pkg::MS_PER_S_Q8) * 64'(window_fill)) / 64'(window_sum);
      want.fps_q8          = (rate > 64'(fwrm_pkg::FPS_MAX)) ? fwrm_pkg::FPS_MAX
                                                             : fwrm_pkg::FPS_W'(rate);
      want.avg_interval_ms = fwrm_pkg::AVG_W'(64'(window_sum) / 64'(window_fill));
      want.zero_interval   = 1'b0;
    end
    expected_readings.push_back(want);
  endtask

  task automatic log_fault(input string what, input meter_reading_t want,
                           input meter_reading_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s: expected fps_q8=%h avg=%0d frames=%0d zero=%b",
               $time, what, want.fps_q8, want.avg_interval_ms,
               want.frames_averaged, want.zero_interval);
      $display("%0t: %s: actual   fps_q8=%h avg=%0d frames=%0d zero=%b",
               $time, what, got.fps_q8, got.avg_interval_ms,
               got.frames_averaged, got.zero_interval);
    end
  endtask

  always @(posedge clk) begin : result_check
    meter_reading_t got;
    meter_reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_fps_q8, out_avg_interval_ms, out_frames_averaged, out_zero_interval};
      if (expected_readings.size() == 0) begin
        log_fault("result beat with nothing pending", '0, got);
      end else begin
        want = expected_readings.pop_front();
        if (got !== want) log_fault("mismatch", want, got);
      end
    end
  end

  task automatic send_frame(input logic [fwrm_pkg::TS_W-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_timestamp_ms <= ts;
    do @(posedge clk); while (in_stall);
    predict_reading(ts);
  endtask

  // first stamp equals the reset value, so the sum starts at zero
  task automatic test_zero_sum_start();
    send_frame('0);
    send_frame('0);
  endtask

  task automatic test_shortest_intervals();
    send_frame(32'd1);
    send_frame(32'd2);
  endtask

  // all-ones, wrap to zero, and a stamp that runs backwards
  task automatic test_timestamp_extremes();
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h0000_0000);
    send_frame(32'h8000_0000);
    send_frame(32'h7FFF_FFFF);
    send_frame(32'h5555_5555);
    send_frame(32'hAAAA_AAAA);
  endtask

  // fill the window past its depth so old intervals get evicted
  task automatic test_window_rollover();
    for (int i = 0; i < 14; i++) begin
      send_frame(meter_last_ts + ((i % 2 == 0) ? 32'd16 : 32'd17));
    end
  endtask

  // runs of one traffic pattern each, from 1 to 24 frames long
  task automatic test_random_frames(input int n_frames, input int idle_pct,
                                    input int hold_pct);
    int                        sent;
    int                        run_left;
    int                        pattern;
    logic [fwrm_pkg::TS_W-1:0] ts;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    sent     = 0;
    run_left = 0;
    pattern  = 0;
    while (sent < n_frames) begin
      if (run_left == 0) begin
        run_left = $urandom_range(24, 1);
        pattern  = $urandom_range(99);
      end
      if (pattern < 55) begin
        ts = meter_last_ts + $urandom_range(100, 1);
      end else if (pattern < 67) begin
        ts = meter_last_ts;
      end else if (pattern < 77) begin
        ts = meter_last_ts - $urandom_range(5000, 1);
      end else if (pattern < 90) begin
        ts = $urandom();
      end else begin
        ts = meter_last_ts + 32'h8000_0000 + $urandom_range(255);
      end
      send_frame(ts);
      sent++;
      run_left--;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_sum_start();
    test_shortest_intervals();
    test_timestamp_extremes();
    test_window_rollover();
    test_random_frames(600, 28, 55);
    test_random_frames(600, 55, 28);
    test_random_frames(550, 0, 0);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (fault_count == 0) begin
      $display("windowed_frame_rate_meter_tb: done, clean");
    end else begin
      $display("windowed_frame_rate_meter_tb: done, errors");
    end
    $finish;
  end

endmodule : windowed_frame_rate_meter_tb
